/* design/lcr_pkg.sv */
// Package for the lattice coefficient rounding unit: constants, codes and widths.
package lcr_pkg;

  localparam int FuncW     = 2;
  localparam int ElemW     = 24;
  localparam int HighW     = 10;
  localparam int LowW      = 18;
  localparam int CoefW     = 23;                 // reduced coefficient, 0..Q-1
  localparam int WideW     = ElemW + 1;          // signed working width

  localparam int Q         = 8380417;
  localparam int D         = 13;
  localparam int Gamma2    = 95232;
  localparam int TwoGamma2 = 2 * Gamma2;
  localparam int HMax      = 43;
  localparam int HalfQ     = (Q - 1) / 2;

  // Reciprocal of 2*GAMMA2 for the bucket estimate
  localparam int PreRound  = 127;
  localparam int PreShift  = 7;
  localparam int TW        = CoefW + 1 - PreShift;   // width of (a + 127) >> 7
  localparam int Mult      = 11275;
  localparam int MulRound  = 1 << 23;
  localparam int ProdW     = 31;
  localparam int ProdShift = 24;
  localparam int HiRawW    = ProdW - ProdShift;      // raw bucket index, up to 44
  localparam int HiW       = 6;                      // bucket index, 0..43

  typedef enum logic [FuncW-1:0] {
    FUNC_POWER2    = 2'd0,
    FUNC_DECOMPOSE = 2'd1,
    FUNC_MAKE_HINT = 2'd2,
    FUNC_USE_HINT  = 2'd3
  } func_e;

endpackage

/* design/lcr_in_if.sv */
// Input item channel: selector, coefficient, high part and hint bit.
interface lcr_in_if;
  import lcr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FuncW-1:0]        func;
  logic signed [ElemW-1:0] elem;
  logic [HighW-1:0]        high_part;
  logic                    hint_in;

  modport source (output valid, func, elem, high_part, hint_in, input ready);
  modport sink   (input valid, func, elem, high_part, hint_in, output ready);
endinterface

/* design/lcr_out_if.sv */
// Result item channel: high bits, low bits and hint flag.
interface lcr_out_if;
  import lcr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [HighW-1:0]       high_out;
  logic signed [LowW-1:0] low_out;
  logic                   hint_out;

  modport source (output valid, high_out, low_out, hint_out, input ready);
  modport sink   (input valid, high_out, low_out, hint_out, output ready);
endinterface

/* design/lattice_coefficient_rounding.sv */
// Four-stage rounding pipeline: reduce mod Q, multiply, bucket, low part and hint fixup.
// Throughput: one item per cycle while out_o is not stalled; each stage holds its own
// valid bit, so a bubble anywhere lets the input side keep taking items while a result
// waits at the output.
// The longest path is the 17x14 constant multiply of stage two.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; payload is not reset.
module lattice_coefficient_rounding (
  input  logic clk_i,
  input  logic rst_ni,
  lcr_in_if.sink    in_i,
  lcr_out_if.source out_o
);
  import lcr_pkg::*;

  // stage enables, walked back from the output register
  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  assign en4 = !v4_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------- stage 1: reduce to 0..Q-1, make hint flag
  func_e            f1_d, f1_q;
  logic [CoefW-1:0] a1_d, a1_q;
  logic             hb1_q, mh1_d, mh1_q;
  logic signed [WideW-1:0] r0, r1, r2;

  always_comb begin
    f1_d = func_e'(in_i.func);
    r0 = WideW'(in_i.elem);
    r1 = (r0 < 0) ? r0 + WideW'(Q) : r0;
    r2 = (r1 < 0) ? r1 + WideW'(Q) : r1;
    if (r2 >= WideW'(Q)) begin
      r2 = r2 - WideW'(Q);
    end
    a1_d = r2[CoefW-1:0];
    mh1_d = (in_i.elem > ElemW'(Gamma2)) || (in_i.elem < -ElemW'(Gamma2)) ||
            ((in_i.elem == -ElemW'(Gamma2)) && (in_i.high_part != '0));
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      f1_q  <= f1_d;
      a1_q  <= a1_d;
      hb1_q <= in_i.hint_in;
      mh1_q <= mh1_d;
    end
  end

  // ---------------- stage 2: bucket estimate product, power-of-two split
  func_e            f2_q;
  logic [CoefW-1:0] a2_q;
  logic             hb2_q, mh2_q;
  logic [ProdW-1:0] prod_d, prod_q;
  logic [HighW-1:0] hp_d, hp2_q;
  logic signed [LowW-1:0] lp_d, lp2_q;
  logic [CoefW:0]   tsum;
  logic [TW-1:0]    t;
  logic [CoefW-1:0] psum;

  always_comb begin
    tsum   = (CoefW+1)'(a1_q) + (CoefW+1)'(PreRound);
    t      = tsum[CoefW:PreShift];
    prod_d = ProdW'(t) * ProdW'(Mult) + ProdW'(MulRound);
    psum   = a1_q + CoefW'((1 << (D - 1)) - 1);
    hp_d   = psum[CoefW-1:D];
    lp_d   = LowW'($signed(WideW'(a1_q)) - $signed(WideW'({hp_d, {D{1'b0}}})));
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      f2_q   <= f1_q;
      a2_q   <= a1_q;
      hb2_q  <= hb1_q;
      mh2_q  <= mh1_q;
      prod_q <= prod_d;
      hp2_q  <= hp_d;
      lp2_q  <= lp_d;
    end
  end

  // ---------------- stage 3: bucket index and its multiple of 2*GAMMA2
  func_e            f3_q;
  logic [CoefW-1:0] a3_q, hm_d, hm3_q;
  logic             hb3_q, mh3_q;
  logic [HiRawW-1:0] hraw;
  logic [HiW-1:0]   hg_d, hg3_q;
  logic [HighW-1:0] hp3_q;
  logic signed [LowW-1:0] lp3_q;

  always_comb begin
    hraw = prod_q[ProdW-1:ProdShift];
    // top bucket wraps to zero
    hg_d = (hraw > HiRawW'(HMax)) ? '0 : hraw[HiW-1:0];
    hm_d = CoefW'(hg_d) * CoefW'(TwoGamma2);
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      f3_q  <= f2_q;
      a3_q  <= a2_q;
      hb3_q <= hb2_q;
      mh3_q <= mh2_q;
      hg3_q <= hg_d;
      hm3_q <= hm_d;
      hp3_q <= hp2_q;
      lp3_q <= lp2_q;
    end
  end

  // ---------------- stage 4: centered low part, hint fixup, output register
  func_e            f4_q;
  logic [HighW-1:0] high_d, high_q;
  logic signed [LowW-1:0] low_d, low_q;
  logic             hint_d, hint_q;
  logic signed [WideW-1:0] lg;
  logic [HiW-1:0]   hu;

  always_comb begin
    lg = $signed(WideW'(a3_q)) - $signed(WideW'(hm3_q));
    if (lg > WideW'(HalfQ)) begin
      lg = lg - WideW'(Q);
    end
    hu = hg3_q;
    if (hb3_q) begin
      if (lg > 0) begin
        hu = (hg3_q == HiW'(HMax)) ? '0 : hg3_q + 1'b1;
      end else begin
        hu = (hg3_q == '0) ? HiW'(HMax) : hg3_q - 1'b1;
      end
    end
    high_d = '0;
    low_d  = '0;
    hint_d = 1'b0;
    unique case (f3_q)
      FUNC_POWER2: begin
        high_d = hp3_q;
        low_d  = lp3_q;
      end
      FUNC_DECOMPOSE: begin
        high_d = HighW'(hg3_q);
        low_d  = lg[LowW-1:0];
      end
      FUNC_MAKE_HINT: begin
        hint_d = mh3_q;
      end
      FUNC_USE_HINT: begin
        high_d = HighW'(hu);
      end
      default: begin
        high_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      f4_q   <= f3_q;
      high_q <= high_d;
      low_q  <= low_d;
      hint_q <= hint_d;
    end
  end

  assign out_o.valid    = v4_q;
  assign out_o.high_out = high_q;
  assign out_o.low_out  = low_q;
  assign out_o.hint_out = hint_q;

  // ---------------- checks
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q && v4_q && !out_o.ready))
    else $error("input blocked while pipeline has a free stage");

  a_hint_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.hint_out) |-> (out_o.high_out == '0 && out_o.low_out == '0))
    else $error("hint flag set with nonzero high or low bits");

  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && f4_q != FUNC_POWER2) |-> (out_o.high_out <= HighW'(HMax)))
    else $error("high bits beyond the last bucket");

  a_low_centered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && f4_q == FUNC_DECOMPOSE) |->
      (out_o.low_out <= LowW'(Gamma2) && out_o.low_out >= -LowW'(Gamma2)))
    else $error("decomposed low part outside the centered range");

endmodule
